[src/bdil5_pkg.sv]
// ----------------------------------------------------------------------------
// bdil5_pkg
// Shared types and constants for the 5x5 binary dilation block.
// ----------------------------------------------------------------------------
package bdil5_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int DIM_W       = 10;
    localparam int GRAY_W      = 8;
    localparam int MASK_W      = 25;
    localparam int POS_W       = 9;
    localparam int WIN         = 5;   // window side
    localparam int HIST_ROWS   = 4;   // rows kept per column in the line store

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 10'd512;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 10'd512;
    localparam logic [GRAY_W-1:0] LEVEL_RESET  = 8'd128;
    localparam logic [MASK_W-1:0] MASK_RESET   = 25'd15728622;  // octagon

    localparam logic [GRAY_W-1:0] DILATED_ON  = 8'd255;
    localparam logic [GRAY_W-1:0] DILATED_OFF = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_BINARIZE_LEVEL = 2'd2,
        REG_ELEMENT_MASK   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [GRAY_W-1:0] gray;
    } pixel_in_t;

    typedef struct packed {
        logic [GRAY_W-1:0] dilated;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic              frame_last;
    } pixel_out_t;

endpackage

[src/bdil5_ram.sv]
// ----------------------------------------------------------------------------
// bdil5_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bdil5_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write to the same address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/bdil5_window.sv]
// ----------------------------------------------------------------------------
// bdil5_window
// 5x5 tap window with frame-edge clipping and masked OR reduction.
// ----------------------------------------------------------------------------
module bdil5_window #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                 clk,
    input  logic                                 shift_en,
    input  logic [bdil5_pkg::WIN-1:0]            col_vec,   // bit 0 newest row
    input  logic [$clog2(MAX_HEIGHT)-1:0]        row,
    input  logic [$clog2(MAX_WIDTH)-1:0]         col,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       frame_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      frame_h,
    input  logic [bdil5_pkg::MASK_W-1:0]         mask,
    output logic                                 hit
);

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int N  = bdil5_pkg::WIN;

    // taps_reg[slot][row]: slot 0 is the newest column
    logic [N-1:0][N-1:0] taps_reg;
    logic [RW+1:0]       row_p2;
    logic [CW+1:0]       col_p2;
    logic [N-1:0]        row_ok;
    logic [N-1:0]        col_ok;
    logic [N*N-1:0]      hits;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            taps_reg <= {taps_reg[N-2:0], col_vec};
        end
    end

    // source row r+2-i and column c+2-j must lie inside the frame
    always_comb
    begin
        row_p2 = (RW+2)'(row) + (RW+2)'(2);
        col_p2 = (CW+2)'(col) + (CW+2)'(2);
        for (int i = 0; i < N; i++)
        begin
            row_ok[i] = (row_p2 >= (RW+2)'(i)) &&
                        ((row_p2 - (RW+2)'(i)) < (RW+2)'(frame_h));
            col_ok[i] = (col_p2 >= (CW+2)'(i)) &&
                        ((col_p2 - (CW+2)'(i)) < (CW+2)'(frame_w));
        end
        for (int r = 0; r < N; r++)
        begin
            for (int c = 0; c < N; c++)
            begin
                hits[r*N+c] = taps_reg[c][r] & mask[r*N+c] & row_ok[r] & col_ok[c];
            end
        end
        hit = |hits;
    end

endmodule

[src/binary_dilation_5x5.sv]
// ----------------------------------------------------------------------------
// binary_dilation_5x5
// Streaming 5x5 binary dilation of a raster-order 8-bit grayscale frame.
//
// src carries one pixel (or flush item) per transfer; dst returns one output
// pixel per transfer with its row, column and an end-of-frame flag. The first
// 2*W+2 transfers of a frame produce nothing; the host appends 2*W+2 flush
// items so the last rows drain. Each frame thus takes W*H + 2*W + 2 input
// transfers and yields W*H output transfers.
// Throughput: one transfer per clock on both sides. The limit is the line
// store, which does one column read and one column write per cycle.
// A result goes from the input transfer that completes its window through the
// stage 1, window and stage 2 registers, then into the output register.
// If dst stalls, the three internal stages keep filling; src_ready drops only
// once all are full. cfg writes take effect at once; a width or height write
// restarts the frame count.
// Reset clears control state and loads the register defaults (512 x 512,
// level 128, octagon element). The line store needs no clearing: rows not yet
// written in the current frame are masked by the frame-edge clipping.
// ----------------------------------------------------------------------------
module binary_dilation_5x5 #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  src_valid,
    output logic                                  src_ready,
    input  bdil5_pkg::pixel_in_t                  src_data,
    output logic                                  dst_valid,
    input  logic                                  dst_ready,
    output bdil5_pkg::pixel_out_t                 dst_data,
    input  logic                                  cfg_we,
    input  logic [bdil5_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bdil5_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);         // column index
    localparam int WW  = $clog2(MAX_WIDTH + 1);     // width value
    localparam int RW  = $clog2(MAX_HEIGHT);        // output row index
    localparam int HW  = $clog2(MAX_HEIGHT + 1);    // height value
    localparam int IRW = $clog2(MAX_HEIGHT + 4);    // input row, runs into flush rows
    localparam int LW  = $clog2(2*MAX_WIDTH + 3);   // start-up lag count
    localparam int HR  = bdil5_pkg::HIST_ROWS;
    localparam int N   = bdil5_pkg::WIN;

    // ---------------- configuration registers ----------------
    logic [bdil5_pkg::DIM_W-1:0]  width_reg;
    logic [bdil5_pkg::DIM_W-1:0]  height_reg;
    logic [bdil5_pkg::GRAY_W-1:0] level_reg;
    logic [bdil5_pkg::MASK_W-1:0] mask_reg;
    logic                         size_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bdil5_pkg::WIDTH_RESET;
            height_reg <= bdil5_pkg::HEIGHT_RESET;
            level_reg  <= bdil5_pkg::LEVEL_RESET;
            mask_reg   <= bdil5_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (bdil5_pkg::cfg_reg_t'(cfg_index))
                bdil5_pkg::REG_FRAME_WIDTH:    width_reg  <= cfg_data[bdil5_pkg::DIM_W-1:0];
                bdil5_pkg::REG_FRAME_HEIGHT:   height_reg <= cfg_data[bdil5_pkg::DIM_W-1:0];
                bdil5_pkg::REG_BINARIZE_LEVEL: level_reg  <= cfg_data[bdil5_pkg::GRAY_W-1:0];
                bdil5_pkg::REG_ELEMENT_MASK:   mask_reg   <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign size_write = cfg_we &&
        (bdil5_pkg::cfg_reg_t'(cfg_index) == bdil5_pkg::REG_FRAME_WIDTH ||
         bdil5_pkg::cfg_reg_t'(cfg_index) == bdil5_pkg::REG_FRAME_HEIGHT);

    // effective frame size: zero acts as one, oversize clamps to the maximum
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [LW-1:0] lag;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);

        if (height_reg == '0)
            eff_h = HW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);

        lag = LW'(2*int'(eff_w) + 2);
    end

    // ---------------- pipeline handshake ----------------
    logic accept;
    logic rdy1, rdy2, rdy3;
    logic adv1, adv2;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;

    assign rdy3      = !out_valid_reg || dst_ready;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign adv2      = s2_valid_reg && rdy3;   // window result into output register
    assign adv1      = s1_valid_reg && rdy2;   // column into window, line store write
    assign src_ready = rdy1;
    assign accept    = src_valid && rdy1;

    // ---------------- input-side position tracking ----------------
    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [IRW-1:0] in_row_reg,  in_row_next;
    logic [LW-1:0]  lead_reg,    lead_next;
    logic [RW-1:0]  orow_reg,    orow_next;
    logic [CW-1:0]  ocol_reg,    ocol_next;
    logic           pixel_phase;
    logic           in_bit;
    logic           emit;
    logic           last;
    logic           in_col_wrap;
    logic           ocol_wrap;

    always_comb
    begin
        // rows beyond the frame are flush rows: stored as background
        pixel_phase = int'(in_row_reg) < int'(eff_h);
        in_bit      = pixel_phase && (src_data.op == bdil5_pkg::OP_PIXEL) &&
                      (src_data.gray >= level_reg);
        emit        = (lead_reg == lag);
        ocol_wrap   = int'(ocol_reg) == int'(eff_w) - 1;
        last        = emit && ocol_wrap && (int'(orow_reg) == int'(eff_h) - 1);
        in_col_wrap = int'(in_col_reg) == int'(eff_w) - 1;

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        lead_next   = lead_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;

        if (size_write || (accept && last))
        begin
            in_col_next = '0;
            in_row_next = '0;
            lead_next   = '0;
            orow_next   = '0;
            ocol_next   = '0;
        end
        else if (accept)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IRW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end

            if (!emit)
            begin
                lead_next = lead_reg + LW'(1);
            end
            else if (ocol_wrap)
            begin
                ocol_next = '0;
                orow_next = orow_reg + RW'(1);
            end
            else
            begin
                ocol_next = ocol_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            lead_reg   <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            lead_reg   <= lead_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic          s1_bit_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [RW-1:0] s1_orow_reg;
    logic [CW-1:0] s1_ocol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rdy1)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg  <= in_bit;
            s1_col_reg  <= in_col_reg;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_orow_reg <= orow_reg;
            s1_ocol_reg <= ocol_reg;
        end
    end

    // Line store: per column, the bits of the four rows above the current one.
    // A held item re-reads its own column so the read word stays valid.
    logic [CW-1:0] ram_raddr;
    logic [HR-1:0] ram_rdata;
    logic [HR-1:0] ram_wdata;
    logic [HR-1:0] hist;
    logic          fwd_reg;
    logic [HR-1:0] fwd_data_reg;
    logic [N-1:0]  col_vec;

    assign ram_raddr = accept ? in_col_reg : s1_col_reg;
    assign hist      = fwd_reg ? fwd_data_reg : ram_rdata;
    assign col_vec   = {hist, s1_bit_reg};
    assign ram_wdata = {hist[HR-2:0], s1_bit_reg};

    bdil5_ram #(
        .WIDTH (HR),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // single-column frames read the column being written in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= adv1 && accept && (in_col_reg == s1_col_reg);
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    // ---------------- stage 2: 5x5 window ----------------
    logic          s2_last_reg;
    logic [RW-1:0] s2_orow_reg;
    logic [CW-1:0] s2_ocol_reg;
    logic          hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_last_reg <= s1_last_reg;
            s2_orow_reg <= s1_orow_reg;
            s2_ocol_reg <= s1_ocol_reg;
        end
    end

    bdil5_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk      (clk),
        .shift_en (adv1),
        .col_vec  (col_vec),
        .row      (s2_orow_reg),
        .col      (s2_ocol_reg),
        .frame_w  (eff_w),
        .frame_h  (eff_h),
        .mask     (mask_reg),
        .hit      (hit)
    );

    // ---------------- output register ----------------
    bdil5_pkg::pixel_out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy3)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            out_data_reg.dilated    <= hit ? bdil5_pkg::DILATED_ON : bdil5_pkg::DILATED_OFF;
            out_data_reg.out_row    <= bdil5_pkg::POS_W'(s2_orow_reg);
            out_data_reg.out_col    <= bdil5_pkg::POS_W'(s2_ocol_reg);
            out_data_reg.frame_last <= s2_last_reg;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_out_from_window : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("output became valid without a pending window result");

    a_lead_bound : assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg <= lag)
        else $error("start-up count ran past the lag");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> adv1)
        else $error("stage 1 overwritten before moving on");

    a_last_emits : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> s1_emit_reg)
        else $error("frame end flagged on an item without output");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 5x5 binary dilation stream.
//
// Pixels and flush items go in over src, a line-store predictor in the bench
// works out each output pixel, and every dst transfer is checked field by
// field against the oldest prediction. Named tests run in turn: default
// level and element, field extremes and item-role corner cases, element and
// level extremes, register writes part-way through a frame, a long dst
// hold-off, the largest frame sizes, a long random stream with noise and
// broken frames, and a final stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb;

    localparam int CFG_INDEX_W  = bdil5_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = bdil5_pkg::CFG_DATA_W;
    localparam int DIM_W        = bdil5_pkg::DIM_W;
    localparam int GRAY_W       = bdil5_pkg::GRAY_W;
    localparam int MASK_W       = bdil5_pkg::MASK_W;
    localparam int POS_W        = bdil5_pkg::POS_W;
    localparam int WIN          = bdil5_pkg::WIN;

    localparam int MAX_W        = 512;
    localparam int MAX_H        = 512;
    localparam int HIST_DEPTH   = 8;          // rows of binary history kept
    localparam int DRAIN_CYCLES = 12;         // three stages plus margin
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLDOFF_LEN  = 300;
    localparam int REPORT_MAX   = 10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   src_valid;
    logic                   src_ready;
    bdil5_pkg::pixel_in_t   src_data;
    logic                   dst_valid;
    logic                   dst_ready;
    bdil5_pkg::pixel_out_t  dst_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: binary history by row mod 8, frame counters, registers
    bit                line_bits [HIST_DEPTH][MAX_W];
    int unsigned       in_count;
    int unsigned       next_row;
    int unsigned       next_col;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [GRAY_W-1:0] level_reg;
    logic [MASK_W-1:0] mask_reg;

    bdil5_pkg::pixel_out_t pending_pixels [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned holdoff_cycles = 0;
    bit          gaps_on        = 1'b1;
    bit          stalls_on      = 1'b1;

    binary_dilation_5x5 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Size registers: 0 behaves as 1, anything above the maximum as the maximum
    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic void restart_frame();
        in_count = 0;
        next_row = 0;
        next_col = 0;
    endfunction

    function automatic void reset_predictor();
        foreach (line_bits[i, j])
            line_bits[i][j] = 1'b0;
        restart_frame();
        width_reg  = bdil5_pkg::WIDTH_RESET;
        height_reg = bdil5_pkg::HEIGHT_RESET;
        level_reg  = bdil5_pkg::LEVEL_RESET;
        mask_reg   = bdil5_pkg::MASK_RESET;
    endfunction

    function automatic void apply_register(bdil5_pkg::cfg_reg_t idx,
                                           logic [CFG_DATA_W-1:0] v);
        case (idx)
            bdil5_pkg::REG_FRAME_WIDTH:
            begin
                width_reg = v[DIM_W-1:0];
                restart_frame();
            end
            bdil5_pkg::REG_FRAME_HEIGHT:
            begin
                height_reg = v[DIM_W-1:0];
                restart_frame();
            end
            bdil5_pkg::REG_BINARIZE_LEVEL: level_reg = v[GRAY_W-1:0];
            bdil5_pkg::REG_ELEMENT_MASK:   mask_reg  = v[MASK_W-1:0];
            default:                       ;
        endcase
    endfunction

    // One accepted item: store its binary value, then emit the output pixel
    // whose window it completes, if any.
    function automatic void predict_dilation(bdil5_pkg::pixel_in_t item);
        int unsigned           w;
        int unsigned           h;
        int unsigned           total;
        int unsigned           lag;
        int unsigned           pos;
        int                    sr;
        int                    sc;
        logic [MASK_W-1:0]     window;
        bdil5_pkg::pixel_out_t res;
        bit                    last;
        w     = clamp_dim(width_reg, MAX_W);
        h     = clamp_dim(height_reg, MAX_H);
        total = w * h;
        lag   = 2 * w + 2;
        pos   = in_count;
        // role goes by position: in the pixel phase a flush item is background
        if (pos < total)
            line_bits[(pos / w) % HIST_DEPTH][pos % w] =
                (item.op == bdil5_pkg::OP_PIXEL) && (item.gray >= level_reg);
        in_count = pos + 1;
        if (pos < lag || pos - lag >= total)
            return;

        // reflected element: bit (k,l) looks at input (r+2-k, c+2-l)
        window = '0;
        for (int b = 0; b < MASK_W; b++)
        begin
            sr = int'(next_row) - (b / WIN - 2);
            sc = int'(next_col) - (b % WIN - 2);
            if (sr >= 0 && sc >= 0 && sr < int'(h) && sc < int'(w))
                window[b] = line_bits[sr % HIST_DEPTH][sc];
        end
        last = (pos - lag) == (total - 1);

        res.dilated    = |(window & mask_reg) ? bdil5_pkg::DILATED_ON
                                              : bdil5_pkg::DILATED_OFF;
        res.out_row    = POS_W'(next_row);
        res.out_col    = POS_W'(next_col);
        res.frame_last = last;
        pending_pixels.push_back(res);

        if (last)
            restart_frame();
        else
        begin
            next_col++;
            if (next_col >= w)
            begin
                next_col = 0;
                next_row++;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_pixel(bdil5_pkg::pixel_out_t got);
        bdil5_pkg::pixel_out_t want;
        if (pending_pixels.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: output with none pending: dilated=%0d row=%0d col=%0d last=%0b",
                         $time, got.dilated, got.out_row, got.out_col, got.frame_last);
        end
        else
        begin
            want = pending_pixels.pop_front();
            if (got.dilated !== want.dilated || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.frame_last !== want.frame_last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("%0t: mismatch on dst transfer", $time);
                    $display("    exp dilated=%0d row=%0d col=%0d last=%0b",
                             want.dilated, want.out_row, want.out_col, want.frame_last);
                    $display("    got dilated=%0d row=%0d col=%0d last=%0b",
                             got.dilated, got.out_row, got.out_col, got.frame_last);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
            check_pixel(dst_data);
    end

    // ------------------------------------------------------------------------
    // dst side: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall_len;
        dst_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles != 0)
            begin
                dst_ready = 1'b0;
                repeat (holdoff_cycles - 1) @(negedge clk);
                holdoff_cycles = 0;
            end
            else if (stalls_on && $urandom_range(5, 0) == 0)
            begin
                dst_ready = 1'b0;
                stall_len = $urandom_range(7, 1);
                repeat (stall_len - 1) @(negedge clk);
            end
            else
                dst_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // src side and register writes
    // ------------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so valid need not drop between back-to-back items.
    task automatic send_item(bdil5_pkg::op_t op, logic [GRAY_W-1:0] gray);
        bdil5_pkg::pixel_in_t item;
        item.op   = op;
        item.gray = gray;
        if (gaps_on && $urandom_range(5, 0) == 0)
        begin
            src_valid = 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge clk);
        end
        src_valid = 1'b1;
        src_data  = item;
        do
            @(posedge clk);
        while (!src_ready);
        predict_dilation(item);
        items_sent++;
        @(negedge clk);
    endtask

    // Wait until every prediction is checked, then let items with no output clear the pipe
    task automatic wait_idle();
        src_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(bdil5_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(posedge clk);
        apply_register(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        cfg_write(bdil5_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(w));
        cfg_write(bdil5_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Sparse foreground by default, otherwise the octagon saturates everything
    function automatic logic [GRAY_W-1:0] pick_gray(int unsigned fg_pct);
        if (level_reg == '0 || $urandom_range(99, 0) < fg_pct)
            return GRAY_W'($urandom_range(255, level_reg));
        return GRAY_W'($urandom_range(level_reg - 1, 0));
    endfunction

    function automatic int unsigned pick_fg_pct();
        if ($urandom_range(4, 0) == 0)
            return $urandom_range(60, 15);
        return $urandom_range(15, 0);
    endfunction

    // noisy: some pixels arrive marked as flush
    task automatic send_pixels(int unsigned n, int unsigned fg_pct, bit noisy);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(3, 0) == 0)
                send_item(bdil5_pkg::OP_FLUSH, GRAY_W'($urandom()));
            else
                send_item(bdil5_pkg::OP_PIXEL, pick_gray(fg_pct));
        end
    endtask

    // noisy: some flush items arrive marked as pixels
    task automatic send_flush(int unsigned n, bit noisy);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(3, 0) == 0)
                send_item(bdil5_pkg::OP_PIXEL, GRAY_W'($urandom()));
            else
                send_item(bdil5_pkg::OP_FLUSH, GRAY_W'($urandom()));
        end
    endtask

    task automatic send_frame(int unsigned fg_pct, bit noisy);
        int unsigned w;
        int unsigned h;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        send_pixels(w * h, fg_pct, noisy);
        send_flush(2 * w + 2, noisy);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_reg_value(bdil5_pkg::cfg_reg_t idx);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom());   // stray upper bits must be dropped
        case (idx)
            bdil5_pkg::REG_FRAME_WIDTH:
                if ($urandom_range(9, 0) == 0)
                    v[DIM_W-1:0] = '0;
                else if ($urandom_range(7, 0) == 0)
                    v[DIM_W-1:0] = DIM_W'($urandom_range(40, 11));
                else
                    v[DIM_W-1:0] = DIM_W'($urandom_range(10, 1));
            bdil5_pkg::REG_FRAME_HEIGHT:
                if ($urandom_range(9, 0) == 0)
                    v[DIM_W-1:0] = '0;
                else
                    v[DIM_W-1:0] = DIM_W'($urandom_range(8, 1));
            bdil5_pkg::REG_BINARIZE_LEVEL:
                case ($urandom_range(7, 0))
                    0:       v[GRAY_W-1:0] = '0;
                    1:       v[GRAY_W-1:0] = '1;
                    default: ;
                endcase
            default:
                case ($urandom_range(5, 0))
                    0:       v = CFG_DATA_W'(1) << $urandom_range(MASK_W - 1, 0);
                    1:       v = bdil5_pkg::MASK_RESET;
                    2:       v = CFG_DATA_W'($urandom()) & CFG_DATA_W'($urandom());
                    3:       v = $urandom_range(1, 0) ? '0 : '1;
                    default: ;
                endcase
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset level 128 and the octagon element, only the size brought down
    task automatic test_default_level_and_mask();
        set_size(6, 5);
        send_frame(10, 1'b0);
        send_frame(3, 1'b0);
        wait_idle();
    endtask

    // Gray extremes and the threshold edge, flush marked items in the pixel
    // phase, pixel marked items in the flush phase, then a 0 x 0 frame
    task automatic test_extremes();
        set_size(3, 3);
        send_item(bdil5_pkg::OP_PIXEL, 8'd0);
        send_item(bdil5_pkg::OP_PIXEL, 8'd255);
        send_item(bdil5_pkg::OP_PIXEL, 8'd127);
        send_item(bdil5_pkg::OP_PIXEL, 8'd128);
        send_item(bdil5_pkg::OP_FLUSH, 8'd255);     // stored as background
        send_item(bdil5_pkg::OP_PIXEL, 8'd0);
        send_item(bdil5_pkg::OP_PIXEL, 8'd0);
        send_item(bdil5_pkg::OP_PIXEL, 8'd0);
        send_item(bdil5_pkg::OP_PIXEL, 8'd128);
        send_item(bdil5_pkg::OP_PIXEL, 8'd255);     // flush phase, gray ignored
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        send_item(bdil5_pkg::OP_FLUSH, 8'd255);
        send_item(bdil5_pkg::OP_PIXEL, 8'd170);
        send_item(bdil5_pkg::OP_FLUSH, 8'd85);
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        wait_idle();
        set_size(0, 0);                  // acts as 1 x 1
        send_item(bdil5_pkg::OP_PIXEL, 8'd255);
        send_item(bdil5_pkg::OP_PIXEL, 8'd255);
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        send_item(bdil5_pkg::OP_FLUSH, 8'd0);
        wait_idle();
    endtask

    task automatic test_element_extremes();
        set_size(7, 6);
        cfg_write(bdil5_pkg::REG_ELEMENT_MASK, '0);
        send_frame(30, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_ELEMENT_MASK, '1);
        send_frame(4, 1'b0);
        for (int b = 0; b < MASK_W; b += 6)
        begin
            wait_idle();
            cfg_write(bdil5_pkg::REG_ELEMENT_MASK, CFG_DATA_W'(1) << b);
            send_frame(8, 1'b0);
        end
        wait_idle();
        cfg_write(bdil5_pkg::REG_ELEMENT_MASK, bdil5_pkg::MASK_RESET);
        cfg_write(bdil5_pkg::REG_BINARIZE_LEVEL, '0);     // everything foreground
        send_frame(0, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_BINARIZE_LEVEL, '1);     // only 255 counts
        send_frame(5, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_BINARIZE_LEVEL, CFG_DATA_W'(bdil5_pkg::LEVEL_RESET));
    endtask

    // Level and element changed part-way, then a size write abandons a frame
    task automatic test_mid_frame_writes();
        set_size(6, 5);
        send_pixels(20, 10, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_BINARIZE_LEVEL, CFG_DATA_W'(200));
        send_pixels(5, 10, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_ELEMENT_MASK, CFG_DATA_W'($urandom()));
        send_pixels(5, 10, 1'b0);
        send_flush(14, 1'b0);
        send_pixels(10, 10, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(7));
        send_frame(10, 1'b0);
        send_pixels(23, 10, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(4));
        send_frame(10, 1'b0);
        wait_idle();
        cfg_write(bdil5_pkg::REG_ELEMENT_MASK, bdil5_pkg::MASK_RESET);
        cfg_write(bdil5_pkg::REG_BINARIZE_LEVEL, CFG_DATA_W'(bdil5_pkg::LEVEL_RESET));
    endtask

    // dst held off long enough that the stages fill and src_ready drops
    task automatic test_backpressure();
        set_size(20, 10);
        gaps_on        = 1'b0;
        holdoff_cycles = HOLDOFF_LEN;
        send_frame(8, 1'b0);
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // Oversized writes clamp to the maximum
    task automatic test_largest_frames();
        set_size(1023, 1);
        send_frame(5, 1'b0);
        wait_idle();
        set_size(1, 1023);
        send_frame(20, 1'b0);
        wait_idle();
    endtask

    // Mostly well-formed frames with random content and settings, the rest
    // noisy frames, short or long flush runs and stray items.
    task automatic test_random_stream();
        int unsigned         start;
        int unsigned         w;
        bdil5_pkg::cfg_reg_t idx;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(2, 0) == 0)
            begin
                wait_idle();
                idx = bdil5_pkg::cfg_reg_t'($urandom_range(3, 0));
                cfg_write(idx, random_reg_value(idx));
            end
            gaps_on   = $urandom_range(3, 0) != 0;
            stalls_on = $urandom_range(3, 0) != 0;
            w = clamp_dim(width_reg, MAX_W);
            case ($urandom_range(9, 0))
                0: send_frame(pick_fg_pct(), 1'b1);
                1:
                begin
                    send_pixels(w * clamp_dim(height_reg, MAX_H), pick_fg_pct(), 1'b0);
                    if ($urandom_range(1, 0))
                        send_flush($urandom_range(2 * w + 1, 0), 1'b0);
                    else
                        send_flush(2 * w + 2 + $urandom_range(w + 3, 1), 1'b0);
                end
                2:
                    repeat ($urandom_range(10, 1))
                        send_item(bdil5_pkg::op_t'($urandom_range(1, 0)),
                                  GRAY_W'($urandom()));
                default: send_frame(pick_fg_pct(), 1'b0);
            endcase
        end
        wait_idle();
    endtask

    task automatic test_no_idle_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_size(9, 4);
        repeat (4)
            send_frame(pick_fg_pct(), 1'b0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = bdil5_pkg::REG_FRAME_WIDTH;
        cfg_data  = '0;
        reset_predictor();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_level_and_mask();
        test_extremes();
        test_element_extremes();
        test_mid_frame_writes();
        test_backpressure();
        test_largest_frames();
        test_random_stream();
        test_no_idle_stream();

        wait_idle();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
src/bdil5_pkg.sv
src/bdil5_ram.sv
src/bdil5_window.sv
src/binary_dilation_5x5.sv
tb/sv/tb.sv
